// ----- rtl/tec_pkg.sv -----
package tec_pkg;

  localparam int FRAC_BITS = 15;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = ONE >> 1;
  localparam int FW        = 16;

  typedef enum logic [0:0] {
    REG_MID_THROTTLE = 1'b0,
    REG_EXPO_AMOUNT  = 1'b1
  } tec_reg_t;

  typedef struct packed {
    logic                 lo;
    logic signed [16:0]   t;
    logic signed [16:0]   t3;
    logic        [FW-1:0] m;
    logic        [FW-1:0] a;
    logic        [FW-1:0] a2;
  } tec_mid_t;

endpackage

// ----- rtl/throttle_expo_curve.sv -----
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   s_tdata[15:0] stick_in
// m_       out  m_tvalid/m_tready   m_tdata[15:0] throttle_out
// cfg_     in   cfg_we              cfg_addr register index, cfg_data value
//
// One beat per cycle sustained while m_tready stays high; each accepted input passes
// through the six register stages of the curve datapath (four multiplier rows).
// Reset clears all stage valid bits and loads mid_throttle 16384, expo_amount 0.
// Each stage advances when empty or when the next one advances, so a stall on
// m_tready fills bubbles before holding s_tready low.
module throttle_expo_curve
  import tec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,   // [15:0] stick_in
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,   // [15:0] throttle_out
  input  logic          cfg_we,
  input  logic [0:0]    cfg_addr,
  input  logic [15:0]   cfg_data
);

  logic [FW-1:0] mid_c;
  logic [FW-1:0] expo_c;
  logic          mid_valid;
  logic          mid_ready;
  tec_mid_t      mid_data;

  tec_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .mid_c    (mid_c),
    .expo_c   (expo_c)
  );

  tec_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (s_tdata),
    .mid_c     (mid_c),
    .expo_c    (expo_c),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  tec_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (m_tdata)
  );

endmodule

// ----- rtl/tec_cfg.sv -----
module tec_cfg
  import tec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_addr,
  input  logic [FW-1:0] cfg_data,
  output logic [FW-1:0] mid_c,
  output logic [FW-1:0] expo_c
);

  logic [FW-1:0] mid_reg;
  logic [FW-1:0] expo_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_reg  <= FW'(HALF);
      expo_reg <= '0;
    end else if (cfg_we) begin
      unique case (tec_reg_t'(cfg_addr))
        REG_MID_THROTTLE: mid_reg  <= cfg_data;
        REG_EXPO_AMOUNT:  expo_reg <= cfg_data;
      endcase
    end
  end

  assign mid_c  = (mid_reg  > FW'(ONE)) ? FW'(ONE) : mid_reg;
  assign expo_c = (expo_reg > FW'(ONE)) ? FW'(ONE) : expo_reg;

endmodule

// ----- rtl/tec_prep.sv -----
module tec_prep
  import tec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [FW-1:0] in_x,
  input  logic [FW-1:0] mid_c,
  input  logic [FW-1:0] expo_c,
  output logic          out_valid,
  input  logic          out_ready,
  output tec_mid_t      out_data
);

  localparam logic signed [17:0] ONE18 = 18'(ONE);

  logic en1, en2, en3;

  logic                 p1_v;
  logic                 p1_lo;
  logic signed [16:0]   p1_t;
  logic        [FW-1:0] p1_m;
  logic        [FW-1:0] p1_a;

  logic                 p2_v;
  logic                 p2_lo;
  logic signed [16:0]   p2_t;
  logic        [FW-1:0] p2_m;
  logic        [FW-1:0] p2_a;
  logic        [FW-1:0] p2_tt;
  logic signed [33:0]   p2_pa;

  logic                 p3_v;
  tec_mid_t             p3;

  logic signed [17:0]   t_raw;
  logic signed [16:0]   t_next;
  logic signed [33:0]   sq;
  logic signed [16:0]   oma;
  logic signed [16:0]   hm;
  logic signed [33:0]   cube;
  logic signed [35:0]   pa_x;
  logic signed [35:0]   p5;
  logic signed [20:0]   a2_sum;
  logic        [FW-1:0] a2_next;

  assign en3      = !p3_v || out_ready;
  assign en2      = !p2_v || en3;
  assign en1      = !p1_v || en2;
  assign in_ready = en1;

  always_comb begin
    t_raw = $signed({1'b0, in_x, 1'b0}) - ONE18;
    if (t_raw > ONE18) begin
      t_next = 17'(ONE);
    end else begin
      t_next = t_raw[16:0];
    end
  end

  assign sq  = p1_t * p1_t;
  assign oma = $signed(17'(ONE)) - $signed({1'b0, p1_a});
  assign hm  = $signed(17'(HALF)) - $signed({1'b0, p1_m});

  always_comb begin
    cube   = $signed({1'b0, p2_tt}) * p2_t;
    pa_x   = 36'(p2_pa);
    p5     = (pa_x <<< 2) + pa_x;
    a2_sum = $signed({5'b0, p2_a}) + 21'($signed(p5[35:16]));
    if (a2_sum < 0) begin
      a2_next = '0;
    end else if (a2_sum > 21'(ONE)) begin
      a2_next = FW'(ONE);
    end else begin
      a2_next = a2_sum[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      p3_v <= 1'b0;
    end else begin
      if (en1) p1_v <= in_valid;
      if (en2) p2_v <= p1_v;
      if (en3) p3_v <= p2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_lo <= (in_x < FW'(HALF));
      p1_t  <= t_next;
      p1_m  <= mid_c;
      p1_a  <= expo_c;
    end
    if (en2) begin
      p2_lo <= p1_lo;
      p2_t  <= p1_t;
      p2_m  <= p1_m;
      p2_a  <= p1_a;
      p2_tt <= sq[30:15];
      p2_pa <= oma * hm;
    end
    if (en3) begin
      p3.lo <= p2_lo;
      p3.t  <= p2_t;
      p3.t3 <= cube[31:15];
      p3.m  <= p2_m;
      p3.a  <= p2_a;
      p3.a2 <= a2_next;
    end
  end

  assign out_valid = p3_v;
  assign out_data  = p3;

endmodule

// ----- rtl/tec_mix.sv -----
module tec_mix
  import tec_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tec_mid_t      in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [FW-1:0] out_res
);

  logic en4, en5, en6;

  logic                 p4_v;
  logic                 p4_lo;
  logic        [FW-1:0] p4_m;
  logic signed [16:0]   p4_lin;
  logic signed [16:0]   p4_cub;

  logic                 p5_v;
  logic                 p5_lo;
  logic        [FW-1:0] p5_m;
  logic        [FW-1:0] p5_om;
  logic        [FW-1:0] p5_ev;

  logic                 p6_v;
  logic        [FW-1:0] p6_res;

  logic        [FW-1:0] ae;
  logic signed [16:0]   oma;
  logic signed [33:0]   lin_p;
  logic signed [33:0]   cub_p;
  logic signed [17:0]   esum;
  logic        [FW-1:0] ev_next;
  logic        [31:0]   pr;
  logic        [16:0]   res_raw;
  logic        [FW-1:0] res_next;

  assign en6      = !p6_v || out_ready;
  assign en5      = !p5_v || en6;
  assign en4      = !p4_v || en5;
  assign in_ready = en4;

  always_comb begin
    ae    = in_data.lo ? in_data.a : in_data.a2;
    oma   = $signed({1'b0, FW'(ONE) - ae});
    lin_p = oma * in_data.t;
    cub_p = $signed({1'b0, ae}) * in_data.t3;
  end

  always_comb begin
    esum = 18'(p4_lin) + 18'(p4_cub);
    if (p4_lo) begin
      if (esum > 0) begin
        ev_next = FW'(ONE);
      end else if (esum < -18'(ONE)) begin
        ev_next = '0;
      end else begin
        ev_next = FW'(esum + 18'(ONE));
      end
    end else begin
      if (esum < 0) begin
        ev_next = '0;
      end else if (esum > 18'(ONE)) begin
        ev_next = FW'(ONE);
      end else begin
        ev_next = esum[FW-1:0];
      end
    end
  end

  always_comb begin
    pr      = p5_om * p5_ev;
    res_raw = p5_lo ? {1'b0, pr[30:15]} : ({1'b0, p5_m} + {1'b0, pr[30:15]});
    if (res_raw > 17'(ONE)) begin
      res_next = FW'(ONE);
    end else begin
      res_next = res_raw[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_v <= 1'b0;
      p5_v <= 1'b0;
      p6_v <= 1'b0;
    end else begin
      if (en4) p4_v <= in_valid;
      if (en5) p5_v <= p4_v;
      if (en6) p6_v <= p5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      p4_lo  <= in_data.lo;
      p4_m   <= in_data.m;
      p4_lin <= lin_p[31:15];
      p4_cub <= cub_p[31:15];
    end
    if (en5) begin
      p5_lo <= p4_lo;
      p5_m  <= p4_m;
      p5_om <= p4_lo ? p4_m : (FW'(ONE) - p4_m);
      p5_ev <= ev_next;
    end
    if (en6) begin
      p6_res <= res_next;
    end
  end

  assign out_valid = p6_v;
  assign out_res   = p6_res;

  a_res_range: assert property (@(posedge clk) disable iff (rst)
    p6_v |-> (p6_res <= FW'(ONE)))
    else $error("result above full scale");

  a_ev_range: assert property (@(posedge clk) disable iff (rst)
    p5_v |-> (p5_ev <= FW'(ONE)))
    else $error("shaped curve value above full scale");

  a_p4_hold: assert property (@(posedge clk) disable iff (rst)
    (p4_v && !en5) |=> (p4_v && $stable(p4_lin) && $stable(p4_cub)))
    else $error("stage four lost its beat under stall");

endmodule
